/* sv/dma_pkg.sv */
// shared types and constants for the density matrix accumulator
`timescale 1ns / 1ps
package dma_pkg;

   localparam int DEF_MAX_BASIS = 64;

   localparam int COEF_W       = 24;
   localparam int DENS_W       = 48;
   localparam int CMD_W        = 2;
   localparam int IDX_W        = 6;
   localparam int BASIS_CNT_W  = 7;
   localparam int ELEC_CNT_W   = 8;
   localparam int ORB_W        = 7;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_BASIS_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELECTRON_COUNT = 1'd1;

   localparam logic [BASIS_CNT_W-1:0] BASIS_COUNT_RST    = 7'd64;
   localparam logic [ELEC_CNT_W-1:0]  ELECTRON_COUNT_RST = 8'd2;

   localparam logic [DENS_W-1:0] DENS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [DENS_W-1:0] DENS_MIN = 48'h8000_0000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_COEF  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [DENS_W-1:0] sum;
      logic              clamp;
   } mac_res_type;

endpackage

/* sv/density_matrix_accumulator_top.sv */
// closed-shell density matrix accumulator, top level with sequencer
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/req_tready  tuser command, tdata coefficient/read_row/read_col
//  rsp      out  rsp_tvalid/rsp_tready  tdata density_value, tuser saturated
//  csr      in   csr_we                 csr_addr register index, csr_wdata value
//
// a coefficient word is written to the row buffer; the word that completes a row starts a pass over
// all n*n entries, one store read-modify-write per cycle through a three-stage pipe
// (n = active basis count); a read word waits on the registered density store read
// clear and reset both sweep all MAX_BASIS^2 store entries to zero with req_tready low
// a stalled rsp word is held in a one-word skid register; no word is taken while that is full
`timescale 1ns / 1ps
module density_matrix_accumulator_top #(
   parameter int MAX_BASIS = dma_pkg::DEF_MAX_BASIS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dma_pkg::REQ_DATA_W-1:0] req_tdata,  // coefficient, read_row, read_col
   input  logic [dma_pkg::CMD_W-1:0]      req_tuser,  // command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dma_pkg::RSP_DATA_W-1:0] rsp_tdata,  // density_value
   output logic [0:0]                     rsp_tuser,  // saturated
   input  logic                           csr_we,
   input  logic [dma_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [dma_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dma_pkg::*;

   localparam int AW    = $clog2(MAX_BASIS);
   localparam int NW    = AW + 1;
   localparam int DEPTH = MAX_BASIS * MAX_BASIS;
   localparam int SW    = $clog2(DEPTH);
   localparam int CW    = (NW > BASIS_CNT_W) ? NW : BASIS_CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_ACCUM = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [BASIS_CNT_W-1:0] basis_cnt_ff, basis_cnt_in;
   logic [ELEC_CNT_W-1:0]  elec_cnt_ff, elec_cnt_in;

   logic [SW-1:0]    clr_addr_ff, clr_addr_in;
   logic [AW-1:0]    bpos_ff, bpos_in;
   logic [ORB_W-1:0] orb_ff, orb_in;
   logic             sat_ff, sat_in;

   logic [AW-1:0] acc_r_ff, acc_r_in;
   logic [AW-1:0] acc_c_ff, acc_c_in;
   logic [SW-1:0] acc_idx_ff, acc_idx_in;
   logic [SW-1:0] acc_base_ff, acc_base_in;

   logic          v1_ff, v2_ff;
   logic [SW-1:0] idx1_ff, idx2_ff;

   logic rd_pend_ff, rd_pend_in;
   logic rd_inr_ff, rd_inr_in;
   logic rd_sat_ff, rd_sat_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DENS_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [DENS_W-1:0]     hold_data_ff, hold_data_in;
   logic                  hold_sat_ff, hold_sat_in;

   cmd_type                  req_cmd;
   logic signed [COEF_W-1:0] req_coef;
   logic [IDX_W-1:0]         req_row;
   logic [IDX_W-1:0]         req_col;
   logic                     req_acc;

   logic [CW-1:0]         bc_ext;
   logic [CW-1:0]         n_cw;
   logic [NW-1:0]         n_act;
   logic [ORB_W-1:0]      occ;
   logic                  row_done;
   logic                  last_c;
   logic                  last_r;
   logic [31:0]           rd_addr_wide;
   logic [SW-1:0]         rd_addr;
   logic                  rd_in_range;

   logic                     buf_we;
   logic signed [COEF_W-1:0] buf_a;
   logic signed [COEF_W-1:0] buf_b;

   logic              mem_we;
   logic [SW-1:0]     mem_waddr;
   logic [DENS_W-1:0] mem_wdata;
   logic [SW-1:0]     mem_raddr;
   logic [DENS_W-1:0] mem_rdata;
   mac_res_type       mac_res;

   logic              rsp_take;
   logic [DENS_W-1:0] rd_result;

   assign req_cmd  = cmd_type'(req_tuser);
   assign req_coef = req_tdata[COEF_W-1:0];
   assign req_row  = req_tdata[COEF_W +: IDX_W];
   assign req_col  = req_tdata[COEF_W+IDX_W +: IDX_W];

   assign req_tready = (state_ff == ST_IDLE) && !rd_pend_ff && !hold_valid_ff;
   assign req_acc    = req_tvalid && req_tready;

   // effective basis count: zero acts as one, clamp at MAX_BASIS
   assign bc_ext = CW'(basis_cnt_ff);
   always_comb begin
      if (basis_cnt_ff == '0) begin
         n_cw = CW'(1);
      end else if (bc_ext > CW'(MAX_BASIS)) begin
         n_cw = CW'(MAX_BASIS);
      end else begin
         n_cw = bc_ext;
      end
   end
   assign n_act = NW'(n_cw);

   assign occ      = ORB_W'(elec_cnt_ff >> 1);
   assign row_done = (NW'(bpos_ff) + NW'(1)) >= n_act;
   assign last_c   = NW'(acc_c_ff) == (n_act - NW'(1));
   assign last_r   = NW'(acc_r_ff) == (n_act - NW'(1));

   assign rd_addr_wide = 32'(req_row) * 32'(MAX_BASIS) + 32'(req_col);
   assign rd_addr      = rd_addr_wide[SW-1:0];
   assign rd_in_range  = (32'(req_row) < 32'(n_act)) && (32'(req_col) < 32'(n_act));

   // configuration registers
   always_comb begin
      basis_cnt_in = basis_cnt_ff;
      elec_cnt_in  = elec_cnt_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_BASIS_COUNT: begin
               basis_cnt_in = csr_wdata[BASIS_CNT_W-1:0];
            end
            CSR_ELECTRON_COUNT: begin
               elec_cnt_in = csr_wdata[ELEC_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      bpos_in     = bpos_ff;
      orb_in      = orb_ff;
      sat_in      = sat_ff;
      acc_r_in    = acc_r_ff;
      acc_c_in    = acc_c_ff;
      acc_idx_in  = acc_idx_ff;
      acc_base_in = acc_base_ff;
      rd_pend_in  = 1'b0;
      rd_inr_in   = rd_inr_ff;
      rd_sat_in   = rd_sat_ff;
      buf_we      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                     bpos_in     = '0;
                     orb_in      = '0;
                     sat_in      = 1'b0;
                  end
                  CMD_COEF: begin
                     if (orb_ff < occ) begin
                        buf_we = 1'b1;
                        if (row_done) begin
                           bpos_in     = '0;
                           orb_in      = orb_ff + ORB_W'(1);
                           state_in    = ST_ACCUM;
                           acc_r_in    = '0;
                           acc_c_in    = '0;
                           acc_idx_in  = '0;
                           acc_base_in = '0;
                        end else begin
                           bpos_in = bpos_ff + AW'(1);
                        end
                     end
                  end
                  CMD_READ: begin
                     rd_pend_in = 1'b1;
                     rd_inr_in  = rd_in_range;
                     rd_sat_in  = sat_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_addr_ff == SW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + SW'(1);
            end
         end
         ST_ACCUM: begin
            if (last_c) begin
               acc_c_in    = '0;
               acc_r_in    = acc_r_ff + AW'(1);
               acc_base_in = acc_base_ff + SW'(MAX_BASIS);
               acc_idx_in  = acc_base_ff + SW'(MAX_BASIS);
               if (last_r) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               acc_c_in   = acc_c_ff + AW'(1);
               acc_idx_in = acc_idx_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            // last write lands on the edge that returns to idle
            if (!v1_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (v2_ff && mac_res.clamp) begin
         sat_in = 1'b1;
      end
   end

   // result register with one-word skid
   assign rsp_take  = rsp_valid_ff && rsp_tready;
   assign rd_result = rd_inr_ff ? mem_rdata : '0;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_sat_in    = rsp_sat_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      hold_sat_in   = hold_sat_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      priority if (hold_valid_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = hold_data_ff;
            rsp_sat_in    = hold_sat_ff;
            hold_valid_in = 1'b0;
         end
      end else if (rd_pend_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_result;
            rsp_sat_in   = rd_sat_ff;
         end else begin
            hold_valid_in = 1'b1;
            hold_data_in  = rd_result;
            hold_sat_in   = rd_sat_ff;
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         basis_cnt_ff  <= BASIS_COUNT_RST;
         elec_cnt_ff   <= ELECTRON_COUNT_RST;
         clr_addr_ff   <= '0;
         bpos_ff       <= '0;
         orb_ff        <= '0;
         sat_ff        <= 1'b0;
         acc_r_ff      <= '0;
         acc_c_ff      <= '0;
         acc_idx_ff    <= '0;
         acc_base_ff   <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         basis_cnt_ff  <= basis_cnt_in;
         elec_cnt_ff   <= elec_cnt_in;
         clr_addr_ff   <= clr_addr_in;
         bpos_ff       <= bpos_in;
         orb_ff        <= orb_in;
         sat_ff        <= sat_in;
         acc_r_ff      <= acc_r_in;
         acc_c_ff      <= acc_c_in;
         acc_idx_ff    <= acc_idx_in;
         acc_base_ff   <= acc_base_in;
         v1_ff         <= state_ff == ST_ACCUM;
         v2_ff         <= v1_ff;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff      <= acc_idx_ff;
      idx2_ff      <= idx1_ff;
      rd_inr_ff    <= rd_inr_in;
      rd_sat_ff    <= rd_sat_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_sat_ff   <= rsp_sat_in;
      hold_data_ff <= hold_data_in;
      hold_sat_ff  <= hold_sat_in;
   end

   // store port muxing: sweep, pipeline write-back, or read command
   assign mem_we    = (state_ff == ST_CLEAR) || v2_ff;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : idx2_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : mac_res.sum;
   assign mem_raddr = v1_ff ? idx1_ff : rd_addr;

   dma_row_buf #(
      .DEPTH(MAX_BASIS)
   ) u_row_buf (
      .clock     (clock),
      .wr_en     (buf_we),
      .wr_addr   (bpos_ff),
      .wr_data   (req_coef),
      .rd_addr_a (acc_r_ff),
      .rd_addr_b (acc_c_ff),
      .rd_data_a (buf_a),
      .rd_data_b (buf_b)
   );

   dma_mac u_mac (
      .clock    (clock),
      .coef_a   (buf_a),
      .coef_b   (buf_b),
      .dens_old (mem_rdata),
      .res      (mac_res)
   );

   dma_dens_mem #(
      .DEPTH(DEPTH)
   ) u_dens_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* sv/dma_row_buf.sv */
// orbital row buffer: one write port, two registered read ports
`timescale 1ns / 1ps
module dma_row_buf #(
   parameter int DEPTH = dma_pkg::DEF_MAX_BASIS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [dma_pkg::COEF_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr_a,
   input  logic [AW-1:0]                     rd_addr_b,
   output logic signed [dma_pkg::COEF_W-1:0] rd_data_a,
   output logic signed [dma_pkg::COEF_W-1:0] rd_data_b
);
   import dma_pkg::*;

   logic signed [COEF_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* sv/dma_dens_mem.sv */
// density store: simple dual-port memory with registered read data
`timescale 1ns / 1ps
module dma_dens_mem #(
   parameter int DEPTH = dma_pkg::DEF_MAX_BASIS * dma_pkg::DEF_MAX_BASIS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [dma_pkg::DENS_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [dma_pkg::DENS_W-1:0] rd_data
);
   import dma_pkg::*;

   logic [DENS_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* sv/dma_mac.sv */
// registered coefficient product and saturating add into a density entry
`timescale 1ns / 1ps
module dma_mac (
   input  logic                              clock,
   input  logic signed [dma_pkg::COEF_W-1:0] coef_a,
   input  logic signed [dma_pkg::COEF_W-1:0] coef_b,
   input  logic [dma_pkg::DENS_W-1:0]        dens_old,
   output dma_pkg::mac_res_type              res
);
   import dma_pkg::*;

   logic signed [DENS_W-1:0] prod_ff;
   logic signed [DENS_W-1:0] prod_in;
   logic [DENS_W:0]          sum_wide;

   // q4.20 times q4.20 is exact in q8.40
   assign prod_in = DENS_W'(coef_a * coef_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign sum_wide = {dens_old[DENS_W-1], dens_old} + {prod_ff[DENS_W-1], prod_ff};

   always_comb begin
      res.clamp = sum_wide[DENS_W] != sum_wide[DENS_W-1];
      if (!res.clamp) begin
         res.sum = sum_wide[DENS_W-1:0];
      end else if (sum_wide[DENS_W]) begin
         res.sum = DENS_MIN;
      end else begin
         res.sum = DENS_MAX;
      end
   end

endmodule

/* sv/dma_checker.sv */
// port-level checks for the density matrix accumulator, bound to the top level
`timescale 1ns / 1ps
module dma_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dma_pkg::CMD_W-1:0]      req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dma_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dma_pkg::*;

   // reset starts the clearing sweep, so no word is taken right after it
   a_reset_blocks_req: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_reset_empties_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a clear word starts a sweep of the store
   a_clear_blocks_req: assert property (@(posedge clock)
      (req_tvalid && req_tready && req_tuser == CMD_CLEAR) |=> !req_tready)
      else $error("word accepted during clearing sweep");

   // a read word blocks the next word while the registered store read is in flight
   a_read_blocks_req: assert property (@(posedge clock)
      (req_tvalid && req_tready && req_tuser == CMD_READ) |=> !req_tready)
      else $error("word accepted while a read is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp word changed or dropped");

endmodule

bind density_matrix_accumulator_top dma_checker u_dma_checker (.*);
